>>> design/mcfb_pkg.sv
// Shared types, constants and the microprogram for the motor command frame builder.
// Depends on nothing; the sequencer, the datapath and the top level import this package.
package mcfb_pkg;

  localparam int unsigned StepW    = 4;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  typedef logic [StepW-1:0] step_t;

  // Program addresses.
  localparam step_t StIdle   = 4'd0;
  localparam step_t StStart  = 4'd1;
  localparam step_t StLength = 4'd2;
  localparam step_t StNode   = 4'd3;
  localparam step_t StMode   = 4'd4;
  localparam step_t StIdxLo  = 4'd5;
  localparam step_t StIdxHi  = 4'd6;
  localparam step_t StSubIdx = 4'd7;
  localparam step_t StPay    = 4'd8;
  localparam step_t StCrc    = 4'd9;
  localparam step_t StEnd    = 4'd10;

  localparam logic [7:0] FrameStart = 8'h53;
  localparam logic [7:0] FrameEnd   = 8'h45;
  localparam logic [7:0] BaseLength = 8'h07;
  localparam logic [7:0] CrcPoly    = 8'hD5;
  localparam logic [7:0] CrcInit    = 8'hFF;
  localparam logic [7:0] ModeRead   = 8'h01;
  localparam logic [7:0] ModeWrite  = 8'h02;
  localparam logic [2:0] MaxPayload = 3'd4;

  localparam logic [CfgIdxW-1:0] RegNodeAddress = 8'd0;
  localparam logic [CfgIdxW-1:0] RegReadIndex   = 8'd1;

  typedef enum logic [3:0] {
    SrcNone, SrcStart, SrcLength, SrcNode, SrcMode, SrcIdxLo,
    SrcIdxHi, SrcZero, SrcPayload, SrcCrc, SrcEnd
  } src_e;

  typedef enum logic [1:0] {CrcHold, CrcLoad, CrcUpdate} crc_op_e;

  typedef enum logic [2:0] {JmpNext, JmpWaitIn, JmpIfEmpty, JmpIfMore, JmpGoto} jmp_e;

  typedef struct packed {
    src_e    src;
    crc_op_e crc_op;
    logic    last;
    jmp_e    jmp;
    step_t   target;
  } uword_t;

  typedef struct packed {
    logic   load;
    logic   fire;
    uword_t uw;
  } dp_ctrl_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
  } dp_stat_t;

  // The microprogram: one control word per step.
  function automatic uword_t prog_rom(input step_t s);
    uword_t w;
    w = '{src: SrcNone, crc_op: CrcHold, last: 1'b0, jmp: JmpGoto, target: StIdle};
    case (s)
      StIdle:   w = '{SrcNone,    CrcHold,   1'b0, JmpWaitIn,  StIdle};
      StStart:  w = '{SrcStart,   CrcLoad,   1'b0, JmpNext,    StIdle};
      StLength: w = '{SrcLength,  CrcUpdate, 1'b0, JmpNext,    StIdle};
      StNode:   w = '{SrcNode,    CrcUpdate, 1'b0, JmpNext,    StIdle};
      StMode:   w = '{SrcMode,    CrcUpdate, 1'b0, JmpNext,    StIdle};
      StIdxLo:  w = '{SrcIdxLo,   CrcUpdate, 1'b0, JmpNext,    StIdle};
      StIdxHi:  w = '{SrcIdxHi,   CrcUpdate, 1'b0, JmpNext,    StIdle};
      StSubIdx: w = '{SrcZero,    CrcUpdate, 1'b0, JmpIfEmpty, StCrc};
      StPay:    w = '{SrcPayload, CrcUpdate, 1'b0, JmpIfMore,  StPay};
      StCrc:    w = '{SrcCrc,     CrcHold,   1'b0, JmpNext,    StIdle};
      StEnd:    w = '{SrcEnd,     CrcHold,   1'b1, JmpGoto,    StIdle};
      default:  w = '{SrcNone,    CrcHold,   1'b0, JmpGoto,    StIdle};
    endcase
    return w;
  endfunction

  // Reflected CRC-8 over one byte, LSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> design/mcfb_if.sv
// Request channel interfaces: command in, frame bytes out.
// Depends on mcfb_pkg for nothing but follows it in compile order.
interface mcfb_cmd_if;
  logic        valid;
  logic        ready;
  logic [15:0] object_index;
  logic [31:0] payload;
  logic [2:0]  payload_bytes;

  modport source (output valid, object_index, payload, payload_bytes, input ready);
  modport sink   (input valid, object_index, payload, payload_bytes, output ready);
endinterface

interface mcfb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

>>> design/mcfb_seq.sv
// Microprogram sequencer: step counter, program table lookup and conditional jumps.
// Depends on mcfb_pkg.
module mcfb_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  logic              out_free_i,
  input  mcfb_pkg::dp_stat_t stat_i,
  output logic              cmd_ready_o,
  output mcfb_pkg::dp_ctrl_t ctrl_o,
  output mcfb_pkg::step_t   step_o
);
  import mcfb_pkg::*;

  step_t  step_q, step_d;
  uword_t uw;
  logic   load, fire;

  always_comb begin
    uw          = prog_rom(step_q);
    cmd_ready_o = (uw.jmp == JmpWaitIn);
    load        = cmd_ready_o & cmd_valid_i;
    // A step that emits a byte executes only when the output register can take it.
    fire        = (uw.src != SrcNone) & out_free_i;
    step_d      = step_q;
    case (uw.jmp)
      JmpWaitIn:  if (load) step_d = step_q + step_t'(1);
      JmpNext:    if (fire) step_d = step_q + step_t'(1);
      JmpIfEmpty: if (fire) step_d = stat_i.cnt_zero ? uw.target : step_q + step_t'(1);
      JmpIfMore:  if (fire) step_d = !stat_i.cnt_one ? uw.target : step_q + step_t'(1);
      JmpGoto:    if (fire) step_d = uw.target;
      default:    step_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StIdle;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = '{load: load, fire: fire, uw: uw};
  assign step_o = step_q;

endmodule

>>> design/mcfb_dp.sv
// Datapath: configuration registers, command holding registers, CRC register,
// byte selection and the output register. Depends on mcfb_pkg.
module mcfb_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mcfb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mcfb_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [15:0]                   object_index_i,
  input  logic [31:0]                   payload_i,
  input  logic [2:0]                    payload_bytes_i,
  input  mcfb_pkg::dp_ctrl_t            ctrl_i,
  input  logic                          out_ready_i,
  output logic                          out_free_o,
  output mcfb_pkg::dp_stat_t            stat_o,
  output logic                          out_valid_o,
  output logic [7:0]                    frame_byte_o,
  output logic                          last_byte_o
);
  import mcfb_pkg::*;

  logic [7:0]  node_q;
  logic [15:0] rdidx_q;
  logic [15:0] idx_q;
  logic [31:0] pay_q;
  logic [2:0]  cnt_q, cnt_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  obyte_q, obyte_d;
  logic        olast_q;
  logic        ovalid_q, ovalid_d;
  logic [7:0]  sel_byte;

  assign out_free_o = !ovalid_q | out_ready_i;
  assign stat_o     = '{cnt_zero: (cnt_q == 3'd0), cnt_one: (cnt_q == 3'd1)};

  always_comb begin
    case (ctrl_i.uw.src)
      SrcStart:   sel_byte = FrameStart;
      SrcLength:  sel_byte = BaseLength + {5'd0, cnt_q};
      SrcNode:    sel_byte = node_q;
      SrcMode:    sel_byte = (idx_q == rdidx_q) ? ModeRead : ModeWrite;
      SrcIdxLo:   sel_byte = idx_q[7:0];
      SrcIdxHi:   sel_byte = idx_q[15:8];
      SrcZero:    sel_byte = 8'h00;
      SrcPayload: sel_byte = pay_q[7:0];
      SrcCrc:     sel_byte = crc_q;
      SrcEnd:     sel_byte = FrameEnd;
      default:    sel_byte = 8'h00;
    endcase

    crc_d = crc_q;
    if (ctrl_i.fire) begin
      case (ctrl_i.uw.crc_op)
        CrcLoad:   crc_d = CrcInit;
        CrcUpdate: crc_d = crc8_byte(crc_q, sel_byte);
        default:   crc_d = crc_q;
      endcase
    end

    // Counts above four are clamped so the frame carries all four bytes.
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      cnt_d = (payload_bytes_i > MaxPayload) ? MaxPayload : payload_bytes_i;
    end else if (ctrl_i.fire && ctrl_i.uw.src == SrcPayload) begin
      cnt_d = cnt_q - 3'd1;
    end

    obyte_d  = ctrl_i.fire ? sel_byte : obyte_q;
    ovalid_d = ctrl_i.fire ? 1'b1 : (ovalid_q & !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q   <= 8'd1;
      rdidx_q  <= 16'd24684;
      cnt_q    <= 3'd0;
      ovalid_q <= 1'b0;
      olast_q  <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == RegNodeAddress) node_q <= cfg_data_i[7:0];
      if (cfg_we_i && cfg_idx_i == RegReadIndex)   rdidx_q <= cfg_data_i;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
      if (ctrl_i.fire) olast_q <= ctrl_i.uw.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      idx_q <= object_index_i;
      pay_q <= payload_i;
    end else if (ctrl_i.fire && ctrl_i.uw.src == SrcPayload) begin
      pay_q <= {8'h00, pay_q[31:8]};
    end
    crc_q   <= crc_d;
    obyte_q <= obyte_d;
  end

  assign out_valid_o  = ovalid_q;
  assign frame_byte_o = obyte_q;
  assign last_byte_o  = olast_q;

endmodule

>>> design/motor_command_frame_builder.sv
// Motor command frame builder: top level joining the sequencer and the datapath.
// Depends on mcfb_pkg, mcfb_if, mcfb_seq and mcfb_dp.
//
// A command request on cmd_i (object index, 32-bit payload, payload byte count)
// becomes one serial frame on frm_o per command, with last_byte set on
// the closing 0x45. A frame is 9 bytes plus the payload size (counts above four
// send four), so up to 13 bytes.
// The microprogram takes a command in its idle step and then executes one step
// per frame byte, each only when the output register is free; the first byte
// reaches frm_o through the step counter and then the output register.
// The next command is taken as soon as the program is back in its idle step,
// even while the end byte still waits in the output register.
// When the receiver holds frm_o.ready low, the program stops on the current
// byte and resumes when the output register frees up; nothing is dropped.
// Registers: index 0 is the node address (reset 1), index 1 the read-mode
// object index (reset 24684); other indices are ignored. Write them only while
// no frame is in progress.
// Reset clears the step counter and output valid; the block is ready for a
// command in the first cycle after reset.
module motor_command_frame_builder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mcfb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mcfb_pkg::CfgDataW-1:0] cfg_data_i,
  mcfb_cmd_if.sink                      cmd_i,
  mcfb_byte_if.source                   frm_o
);
  import mcfb_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;
  step_t    step;
  logic     out_free;

  mcfb_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .out_free_i  (out_free),
    .stat_i      (stat),
    .cmd_ready_o (cmd_i.ready),
    .ctrl_o      (ctrl),
    .step_o      (step)
  );

  mcfb_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .object_index_i  (cmd_i.object_index),
    .payload_i       (cmd_i.payload),
    .payload_bytes_i (cmd_i.payload_bytes),
    .ctrl_i          (ctrl),
    .out_ready_i     (frm_o.ready),
    .out_free_o      (out_free),
    .stat_o          (stat),
    .out_valid_o     (frm_o.valid),
    .frame_byte_o    (frm_o.frame_byte),
    .last_byte_o     (frm_o.last_byte)
  );

  // Only the end marker carries the last flag; a 0x45 byte without the flag is allowed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frm_o.valid |-> (frm_o.last_byte == (frm_o.frame_byte == FrameEnd) ||
                     !frm_o.last_byte && frm_o.frame_byte == FrameEnd))
    else $error("last_byte does not match end marker");

  // A taken command starts the frame with the start step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> (step == StStart))
    else $error("command taken but frame did not start");

  // The program counter never leaves the program.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step <= StEnd)
    else $error("step counter out of program range");

  // The start byte always leaves through a free output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.fire && ctrl.uw.src == SrcStart) |=> (frm_o.valid && frm_o.frame_byte == FrameStart))
    else $error("start byte not presented after start step");

endmodule
